// ===== rtl/swmdg_pkg.sv =====
// Shared constants, register indexes and sequencer states of the sliding-window gap block.
`default_nettype none

package swmdg_pkg;

    localparam int PIX_W       = 18;   // pixel value, two's complement
    localparam int GAP_W       = 18;   // unsigned gap result
    localparam int IDX_W       = 5;    // window row / column on the result
    localparam int CFG_W       = 6;    // widest configuration register
    localparam int CFG_IDX_W   = 2;    // register index
    localparam int S_TDATA_W   = 24;   // input tdata, padded to whole bytes
    localparam int M_TDATA_W   = 32;   // result tdata, padded to whole bytes
    localparam int MAX_DIM_DEF = 32;   // default largest frame side

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,     // wait for an item
        ST_LOAD_P,   // read the outer element
        ST_WAIT_P,   // latch the outer element
        ST_SCAN,     // stream the inner elements past the compare unit
        ST_DRAIN,    // compare the last inner element, advance the outer one
        ST_DONE      // hand the result to the output register
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_min_distinct_gap.sv =====
// Top level: frame store plus a pairwise compare sequencer for the window minimum gap.
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  ----------------------------------------------
//  s_        in   s_tvalid / s_tready    s_tdata[17:0] pixel_value
//  m_        out  m_tvalid / m_tready    m_tdata min_gap, win_row, win_col; m_tlast
//  cfg_      in   cfg_we (no wait)       cfg_addr register index, cfg_wdata value
//
//  An item that closes no window leaves the sequencer idle. An item that closes a k-by-k
//  window (n = k*k elements, k >= 2) sends every pair of window elements through the
//  single subtract/compare unit, fed by the one read port of the frame store; each outer
//  element is latched and compared with each later one. With k = 1 the gap is 0.
//  Reset is synchronous and active low; the frame store is not cleared and needs no pass.
//  The input stays ready while a finished result waits on m_tready; a stalled result
//  only holds the sequencer in its final step.
`default_nettype none

module sliding_window_min_distinct_gap
    import swmdg_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,    // [17:0] pixel_value, [23:18] zero
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,    // [17:0] min_gap, [22:18] win_row,
                                                   // [27:23] win_col, [31:28] zero
    output logic                       m_tlast,    // last_window
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);   // holds any effective dimension

    // Clamp a raw register: zero acts as one, anything above MAX_DIM acts as MAX_DIM.
    function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] raw);
        logic [DW-1:0] v;
        if (raw == '0) begin
            v = DW'(1);
        end else if (32'(raw) > MAX_DIM) begin
            v = DW'(MAX_DIM);
        end else begin
            v = DW'(raw);
        end
        return v;
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] row,
                                                input logic [DW-1:0] col);
        return AW'(32'(row) * MAX_DIM + 32'(col));
    endfunction

    // Raster step inside the window: {row, col}.
    function automatic logic [2*DW-1:0] win_step(input logic [DW-1:0] i,
                                                 input logic [DW-1:0] j,
                                                 input logic [DW-1:0] km1);
        logic [2*DW-1:0] nxt;
        if (j == km1) begin
            nxt = {i + DW'(1), DW'(0)};
        end else begin
            nxt = {i, j + DW'(1)};
        end
        return nxt;
    endfunction

    // Control state
    state_t         state_reg,    state_next;
    logic [CFG_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [CFG_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [CFG_W-1:0] win_cfg_reg,  win_cfg_next;
    logic [DW-1:0]  row_pos_reg,  row_pos_next;
    logic [DW-1:0]  col_pos_reg,  col_pos_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic           pend_reg,     pend_next;

    // Working payload
    logic [DW-1:0]    top_reg,  top_next;
    logic [DW-1:0]    left_reg, left_next;
    logic             last_reg, last_next;
    logic [DW-1:0]    pi_reg,   pi_next;
    logic [DW-1:0]    pj_reg,   pj_next;
    logic [DW-1:0]    qi_reg,   qi_next;
    logic [DW-1:0]    qj_reg,   qj_next;
    logic [PIX_W-1:0] a_reg,    a_next;
    logic [GAP_W-1:0] best_reg, best_next;
    logic [GAP_W-1:0] m_gap_reg,  m_gap_next;
    logic [IDX_W-1:0] m_row_reg,  m_row_next;
    logic [IDX_W-1:0] m_col_reg,  m_col_next;
    logic             m_last_reg, m_last_next;

    // Geometry
    logic [DW-1:0] rows, cols, k, km1;
    assign rows = eff_dim(rows_cfg_reg);
    assign cols = eff_dim(cols_cfg_reg);
    assign k    = eff_dim(win_cfg_reg);
    assign km1  = k - DW'(1);

    // Position of the arriving item; restart the frame if the geometry shrank under it.
    logic          pos_out;
    logic [DW-1:0] r_cur, c_cur;
    logic          produce;
    logic          c_wrap, r_wrap;
    assign pos_out = (row_pos_reg >= rows) || (col_pos_reg >= cols);
    assign r_cur   = pos_out ? '0 : row_pos_reg;
    assign c_cur   = pos_out ? '0 : col_pos_reg;
    assign produce = (k <= rows) && (k <= cols) && (r_cur >= km1) && (c_cur >= km1);
    assign c_wrap  = (c_cur == cols - DW'(1));
    assign r_wrap  = (r_cur == rows - DW'(1));

    // Frame store
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [PIX_W-1:0] ram_rdata;

    assign ram_waddr = cell_addr(r_cur, c_cur);

    swmdg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[PIX_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared subtract/compare unit: distance between the outer element and the streamed one.
    logic [PIX_W:0]   diff;
    logic [PIX_W:0]   mag_w;
    logic [GAP_W-1:0] mag;
    assign diff  = {ram_rdata[PIX_W-1], ram_rdata} - {a_reg[PIX_W-1], a_reg};
    assign mag_w = diff[PIX_W] ? (~diff + (PIX_W+1)'(1)) : diff;
    assign mag   = GAP_W'(mag_w);

    // Window walk
    logic [2*DW-1:0] p_step, q_step;
    logic            q_last, p_next_last;
    assign p_step      = win_step(pi_reg, pj_reg, km1);
    assign q_step      = win_step(qi_reg, qj_reg, km1);
    assign q_last      = (qi_reg == km1) && (qj_reg == km1);
    assign p_next_last = (p_step[2*DW-1:DW] == km1) && (p_step[DW-1:0] == km1);

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        win_cfg_next  = win_cfg_reg;
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        m_tvalid_next = m_tvalid_reg;
        pend_next     = pend_reg;
        top_next      = top_reg;
        left_next     = left_reg;
        last_next     = last_reg;
        pi_next       = pi_reg;
        pj_next       = pj_reg;
        qi_next       = qi_reg;
        qj_next       = qj_reg;
        a_next        = a_reg;
        best_next     = best_reg;
        m_gap_next    = m_gap_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_raddr     = cell_addr(top_reg + pi_reg, left_reg + pj_reg);

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // fold the element read last cycle into the running minimum
        if (pend_reg) begin
            if ((mag != '0) && ((best_reg == '0) || (mag < best_reg))) begin
                best_next = mag;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ram_we = 1'b1;
                    if (c_wrap) begin
                        col_pos_next = '0;
                        row_pos_next = r_wrap ? '0 : r_cur + DW'(1);
                    end else begin
                        col_pos_next = c_cur + DW'(1);
                        row_pos_next = r_cur;
                    end
                    if (produce) begin
                        top_next  = r_cur - km1;
                        left_next = c_cur - km1;
                        last_next = r_wrap && c_wrap;
                        best_next = '0;
                        pi_next   = '0;
                        pj_next   = '0;
                        pend_next = 1'b0;
                        state_next = (k == DW'(1)) ? ST_DONE : ST_LOAD_P;
                    end
                end
            end
            ST_LOAD_P: begin
                state_next = ST_WAIT_P;
            end
            ST_WAIT_P: begin
                a_next     = ram_rdata;
                qi_next    = p_step[2*DW-1:DW];
                qj_next    = p_step[DW-1:0];
                pend_next  = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                ram_raddr = cell_addr(top_reg + qi_reg, left_reg + qj_reg);
                pend_next = 1'b1;
                if (q_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    qi_next = q_step[2*DW-1:DW];
                    qj_next = q_step[DW-1:0];
                end
            end
            ST_DRAIN: begin
                pend_next = 1'b0;
                if (p_next_last) begin
                    state_next = ST_DONE;
                end else begin
                    pi_next    = p_step[2*DW-1:DW];
                    pj_next    = p_step[DW-1:0];
                    state_next = ST_LOAD_P;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_gap_next    = best_reg;
                    m_row_next    = IDX_W'(top_reg);
                    m_col_next    = IDX_W'(left_reg);
                    m_last_next   = last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block itself does not enforce it
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_ROWS: begin
                    rows_cfg_next = cfg_wdata;
                    row_pos_next  = '0;
                    col_pos_next  = '0;
                end
                REG_FRAME_COLS: begin
                    cols_cfg_next = cfg_wdata;
                    row_pos_next  = '0;
                    col_pos_next  = '0;
                end
                REG_WINDOW_SIZE: begin
                    win_cfg_next = cfg_wdata;
                end
                default: begin
                    win_cfg_next = win_cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rows_cfg_reg <= CFG_W'(1);
            cols_cfg_reg <= CFG_W'(1);
            win_cfg_reg  <= CFG_W'(1);
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            win_cfg_reg  <= win_cfg_next;
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg    <= top_next;
        left_reg   <= left_next;
        last_reg   <= last_next;
        pi_reg     <= pi_next;
        pj_reg     <= pj_next;
        qi_reg     <= qi_next;
        qj_reg     <= qj_next;
        a_reg      <= a_next;
        best_reg   <= best_next;
        m_gap_reg  <= m_gap_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - GAP_W - 2*IDX_W){1'b0}}, m_col_reg, m_row_reg, m_gap_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/swmdg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swmdg_ram #(
    parameter  int WIDTH = 18,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== tb/sliding_window_min_distinct_gap_tb.sv =====
// Self-checking testbench for the sliding-window minimum distinct gap block.
`timescale 1ns / 1ps

module sliding_window_min_distinct_gap_tb;
    import swmdg_pkg::*;

    // index 3 has no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    localparam int STORE_DEPTH   = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 110;
    localparam int PIX_MAX       = 100000;

    // One window result as the block should report it.
    typedef struct packed {
        logic [GAP_W-1:0] gap;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } window_result_t;

    // Tracks frame contents and geometry, predicts every window and checks the results.
    class gap_scoreboard;
        logic signed [PIX_W-1:0] store [STORE_DEPTH];
        logic [CFG_W-1:0]        rows_reg;
        logic [CFG_W-1:0]        cols_reg;
        logic [CFG_W-1:0]        ksize_reg;
        logic [CFG_W-1:0]        row_pos;
        logic [CFG_W-1:0]        col_pos;
        window_result_t          expected_windows [$];
        int                      mismatches;
        int                      windows_checked;

        function new();
            rows_reg        = 1;
            cols_reg        = 1;
            ksize_reg       = 1;
            row_pos         = 0;
            col_pos         = 0;
            mismatches      = 0;
            windows_checked = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        // Zero acts as one, anything above the largest side acts as the largest side.
        function int clamp_dim(logic [CFG_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
            return int'(v);
        endfunction

        // Geometry writes restart the frame; a window size write does not.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_FRAME_ROWS: begin
                    rows_reg = val;
                    row_pos  = 0;
                    col_pos  = 0;
                end
                REG_FRAME_COLS: begin
                    cols_reg = val;
                    row_pos  = 0;
                    col_pos  = 0;
                end
                REG_WINDOW_SIZE: ksize_reg = val;
                default: ;
            endcase
        endfunction

        // Sort the window and take the smallest nonzero step between neighbors.
        function logic [GAP_W-1:0] window_gap(int top, int left, int k);
            int vals [STORE_DEPTH];
            int n;
            int v;
            int j;
            int best;
            n    = 0;
            best = 0;
            for (int i = 0; i < k; i++) begin
                for (int c = 0; c < k; c++) begin
                    vals[n] = store[(top + i) * MAX_DIM_DEF + left + c];
                    n++;
                end
            end
            for (int i = 1; i < n; i++) begin
                v = vals[i];
                j = i;
                while (j > 0 && vals[j-1] > v) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = v;
            end
            for (int i = 1; i < n; i++) begin
                if (vals[i] != vals[i-1] && (best == 0 || vals[i] - vals[i-1] < best))
                    best = vals[i] - vals[i-1];
            end
            return GAP_W'(best);
        endfunction

        // Store one accepted pixel and queue the window it closes, if any.
        function void take_pixel(logic signed [PIX_W-1:0] v);
            int rows;
            int cols;
            int k;
            int r;
            int c;
            window_result_t w;
            rows = clamp_dim(rows_reg);
            cols = clamp_dim(cols_reg);
            k    = clamp_dim(ksize_reg);
            r    = int'(row_pos);
            c    = int'(col_pos);
            if (r >= rows || c >= cols) begin
                r = 0;
                c = 0;
            end
            store[r * MAX_DIM_DEF + c] = v;
            if (k <= rows && k <= cols && r + 1 >= k && c + 1 >= k) begin
                w.gap  = (k == 1) ? '0 : window_gap(r + 1 - k, c + 1 - k, k);
                w.row  = IDX_W'(r + 1 - k);
                w.col  = IDX_W'(c + 1 - k);
                w.last = (r == rows - 1 && c == cols - 1);
                expected_windows.insert(expected_windows.size(), w);
            end
            c++;
            if (c >= cols) begin
                c = 0;
                r++;
                if (r >= rows) r = 0;
            end
            row_pos = CFG_W'(r);
            col_pos = CFG_W'(c);
        endfunction

        task report_mismatch(string field, int got, int want);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at window %0d: %s got %0d, expected %0d",
                         windows_checked, field, got, want);
        endtask

        // Compare one accepted result with the oldest pending window.
        task check_result(logic [M_TDATA_W-1:0] data, logic last);
            window_result_t want;
            if (expected_windows.size() == 0) begin
                report_mismatch("result with no window pending, min_gap",
                                int'(data[GAP_W-1:0]), -1);
                return;
            end
            want = expected_windows.pop_front();
            windows_checked++;
            if (data[GAP_W-1:0] != want.gap)
                report_mismatch("min_gap", int'(data[GAP_W-1:0]), int'(want.gap));
            if (data[GAP_W+IDX_W-1:GAP_W] != want.row)
                report_mismatch("win_row", int'(data[GAP_W+IDX_W-1:GAP_W]), int'(want.row));
            if (data[GAP_W+2*IDX_W-1:GAP_W+IDX_W] != want.col)
                report_mismatch("win_col", int'(data[GAP_W+2*IDX_W-1:GAP_W+IDX_W]),
                                int'(want.col));
            if (last != want.last)
                report_mismatch("last_window", int'(last), int'(want.last));
        endtask
    endclass

    // Every input of the block starts at a known value.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    gap_scoreboard gap_sb = new();

    bit src_idle  = 1'b0;   // sender inserts random gaps between items
    bit sink_idle = 1'b0;   // receiver stalls at random before each result
    int pixels_sent = 0;
    int reg_writes  = 0;
    int cycles      = 0;

    sliding_window_min_distinct_gap u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a runaway sequencer ends the run here.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Verification failed");
        $finish;
    end

    // Result monitor: sample at the edge, so values are those the block sees too.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            gap_sb.check_result(m_tdata, m_tlast);
    end

    // Receiver: draw a stall per result, then hold tready until a result is taken.
    initial begin
        int wait_cycles;
        while (!aresetn) @(posedge aclk);
        forever begin
            wait_cycles = sink_idle ? $urandom_range(0, 10) : 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one pixel; keep tvalid high across back-to-back items so it is never
    // lowered and raised in the same step.
    task automatic push_pixel(input logic signed [PIX_W-1:0] v);
        int gap_cycles;
        gap_cycles = src_idle ? $urandom_range(0, 10) : 0;
        if (gap_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-PIX_W){1'b0}}, v};
        do @(posedge aclk); while (!s_tready);
        gap_sb.take_pixel(v);
        pixels_sent++;
    endtask

    // Drop tvalid, wait for every pending window, then let the last item finish.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (gap_sb.expected_windows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Drive the write strobe, index and value; cfg_release drops the strobe after a burst of writes.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        gap_sb.write_reg(idx, val);
        reg_writes++;
    endtask

    task automatic cfg_release();
        cfg_we <= 1'b0;
    endtask

    // Mostly small frames, now and then a zero, a large side or an oversized value.
    function automatic logic [CFG_W-1:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return CFG_W'($urandom_range(1, 6));
        if (sel == 7) return '0;
        if (sel == 8) return CFG_W'($urandom_range(7, MAX_DIM_DEF));
        return CFG_W'($urandom_range(MAX_DIM_DEF + 1, 63));
    endfunction

    // Narrow values force repeats and zero gaps; the wide range of +-PIX_MAX exercises every bit.
    function automatic logic signed [PIX_W-1:0] random_pixel(int style);
        int v;
        case (style)
            0: v = int'($urandom_range(0, 6)) - 3;
            1: v = int'($urandom_range(0, 2 * PIX_MAX)) - PIX_MAX;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = -PIX_MAX;
                    1: v = PIX_MAX;
                    2: v = 0;
                    3: v = -1;
                    default: v = int'($urandom_range(0, 200)) - 100;
                endcase
            end
        endcase
        return PIX_W'(v);
    endfunction

    initial begin
        int rand_items;
        int min_side;
        int sel;
        int k;
        int style;
        int frame_size;
        int n;
        rand_items = 0;

        // Hold reset low at the start, then release it once for the whole run.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset geometry is a 1x1 frame with k = 1: every pixel is its own
        // window with gap 0 and marks the last window. Push the value extremes.
        push_pixel(0);
        push_pixel(-1);
        push_pixel(PIX_W'(PIX_MAX));
        push_pixel(PIX_W'(-PIX_MAX));
        push_pixel(1);

        // 2x2 frame, k = 2: opposite extremes give a gap of 2 * PIX_MAX.
        settle_block();
        cfg_write(REG_FRAME_ROWS, 2);
        cfg_write(REG_FRAME_COLS, 2);
        cfg_write(REG_WINDOW_SIZE, 2);
        cfg_release();
        push_pixel(PIX_W'(PIX_MAX));
        push_pixel(PIX_W'(-PIX_MAX));
        push_pixel(PIX_W'(-PIX_MAX));
        push_pixel(PIX_W'(PIX_MAX));

        // 2x3 frame, k = 2: restart the frame partway with a geometry write,
        // then fill it with equal values so every window has gap 0.
        settle_block();
        cfg_write(REG_FRAME_COLS, 3);
        cfg_release();
        repeat (3) push_pixel(5);
        settle_block();
        cfg_write(REG_FRAME_COLS, 3);
        cfg_release();
        repeat (6) push_pixel(7);

        // Zero rows and window act as one, oversized columns act as the largest side.
        settle_block();
        cfg_write(REG_FRAME_ROWS, 0);
        cfg_write(REG_FRAME_COLS, 63);
        cfg_write(REG_WINDOW_SIZE, 0);
        cfg_release();
        push_pixel(-100);
        push_pixel(100);

        // Window larger than the frame: pixels are stored, nothing comes out.
        // The write to the unused index must leave the geometry alone.
        settle_block();
        cfg_write(REG_FRAME_ROWS, 2);
        cfg_write(REG_FRAME_COLS, 2);
        cfg_write(REG_WINDOW_SIZE, 63);
        cfg_write(REG_UNUSED, 63);
        cfg_release();
        repeat (4) push_pixel(random_pixel(1));

        // Random phases: new geometry or only a new window size, random idling per phase.
        while (rand_items < RANDOM_ITEMS) begin
            settle_block();
            if ($urandom_range(0, 2) != 0) begin
                cfg_write(REG_FRAME_ROWS, pick_dim());
                cfg_write(REG_FRAME_COLS, pick_dim());
            end
            if ($urandom_range(0, 7) == 0)
                cfg_write(REG_UNUSED, CFG_W'($urandom_range(0, 63)));

            min_side = gap_sb.clamp_dim(gap_sb.rows_reg);
            if (gap_sb.clamp_dim(gap_sb.cols_reg) < min_side)
                min_side = gap_sb.clamp_dim(gap_sb.cols_reg);

            // Keep windows small: compare time grows with the square of k*k.
            sel = $urandom_range(0, 19);
            if (sel < 12)
                k = $urandom_range(1, (min_side < 4) ? min_side : 4);
            else if (sel < 15 && min_side >= 5)
                k = $urandom_range(5, (min_side < 6) ? min_side : 6);
            else if (sel < 18 && min_side < MAX_DIM_DEF)
                k = $urandom_range(min_side + 1, 63);
            else
                k = 0;
            cfg_write(REG_WINDOW_SIZE, CFG_W'(k));
            cfg_release();

            src_idle  = ($urandom_range(0, 2) != 0);
            sink_idle = ($urandom_range(0, 2) != 0);
            style     = $urandom_range(0, 2);

            // Half the time push up to a whole frame, at most 36 pixels, so wrap and last window come up.
            frame_size = gap_sb.clamp_dim(gap_sb.rows_reg) * gap_sb.clamp_dim(gap_sb.cols_reg);
            if ($urandom_range(0, 1) != 0)
                n = (frame_size < 36) ? frame_size : 36;
            else
                n = $urandom_range(1, 12);
            repeat (n) begin
                push_pixel(random_pixel(style));
                rand_items++;
            end
        end

        settle_block();
        if (gap_sb.expected_windows.size() != 0)
            gap_sb.report_mismatch("windows never reported, count",
                                   gap_sb.expected_windows.size(), 0);

        $display("Sent %0d pixels through %0d register writes; checked %0d windows.",
                 pixels_sent, reg_writes, gap_sb.windows_checked);
        $display("Mismatches: %0d, cycles used: %0d", gap_sb.mismatches, cycles);
        if (gap_sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/swmdg_pkg.sv
rtl/swmdg_ram.sv
rtl/sliding_window_min_distinct_gap.sv
tb/sliding_window_min_distinct_gap_tb.sv
